// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker in tma_checker.sv.
// Each macro takes a label, clock, active-low reset, antecedent and consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication.
`define TMA_ASSERT_IMP(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
        else $error("tma check failed");
// Next-cycle implication.
`define TMA_ASSERT_NXT(lbl, ck, rn, a, c) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
        else $error("tma check failed");
`endif

// ===== hdl/tma_pkg.sv =====
// Shared types, operation codes and helper functions for the transform matrix block.
// No dependencies.
package tma_pkg;

    typedef logic signed [31:0] fx_t;

    // func codes
    localparam logic [2:0] FN_IDENT = 3'd0;
    localparam logic [2:0] FN_ROT   = 3'd1;
    localparam logic [2:0] FN_SCALE = 3'd2;
    localparam logic [2:0] FN_TRANS = 3'd3;
    localparam logic [2:0] FN_LOAD  = 3'd4;
    localparam logic [2:0] FN_MULS  = 3'd5;
    localparam logic [2:0] FN_READ  = 3'd6;
    localparam logic [2:0] FN_NONE  = 3'd7;   // unused code, dropped

    // right-hand operand kinds for one matrix product
    localparam logic [1:0] OK_TRANS = 2'd0;
    localparam logic [1:0] OK_ROT   = 2'd1;
    localparam logic [1:0] OK_SCALE = 2'd2;
    localparam logic [1:0] OK_STORE = 2'd3;

    localparam int unsigned ATAN_LEN = 24;
    localparam logic signed [33:0] CORDIC_KINV = 34'sd652032874;

    // queued command after classification
    typedef struct packed {
        logic [2:0] op;
        logic       pivoted;
        fx_t        angle;
        fx_t        px;
        fx_t        py;
        fx_t        a;
        fx_t        b;
        logic [3:0] idx;
    } cmd_t;

    function automatic fx_t sat32(input logic signed [63:0] v);
        fx_t r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic fx_t neg_sat(input fx_t v);
        logic signed [63:0] w;
        w = -{{32{v[31]}}, v};
        return sat32(w);
    endfunction

    // arctangent table in degrees, 24 fraction bits
    function automatic logic [31:0] atan_q24(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'd754974720;
            5'd1:    r = 32'd445687602;
            5'd2:    r = 32'd235489088;
            5'd3:    r = 32'd119537938;
            5'd4:    r = 32'd60000934;
            5'd5:    r = 32'd30029717;
            5'd6:    r = 32'd15018523;
            5'd7:    r = 32'd7509720;
            5'd8:    r = 32'd3754917;
            5'd9:    r = 32'd1877466;
            5'd10:   r = 32'd938734;
            5'd11:   r = 32'd469367;
            5'd12:   r = 32'd234684;
            5'd13:   r = 32'd117342;
            5'd14:   r = 32'd58671;
            5'd15:   r = 32'd29335;
            5'd16:   r = 32'd14668;
            5'd17:   r = 32'd7334;
            5'd18:   r = 32'd3667;
            5'd19:   r = 32'd1833;
            5'd20:   r = 32'd917;
            5'd21:   r = 32'd458;
            5'd22:   r = 32'd229;
            5'd23:   r = 32'd115;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hdl/tma_front.sv =====
// Front end: accepts input transactions, classifies them, and queues commands.
// Depends on tma_pkg.
module tma_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [2:0]       func,
    input  tma_pkg::fx_t     angle_deg,
    input  tma_pkg::fx_t     pivot_x,
    input  tma_pkg::fx_t     pivot_y,
    input  tma_pkg::fx_t     scale_x,
    input  tma_pkg::fx_t     scale_y,
    input  tma_pkg::fx_t     shift_x,
    input  tma_pkg::fx_t     shift_y,
    input  logic [3:0]       element_index,
    input  tma_pkg::fx_t     element_value,
    output tma_pkg::cmd_t    q_cmd,
    output logic             q_valid,
    input  logic             q_pop
);
    import tma_pkg::*;

    cmd_t       q_mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    cmd_t       cls;
    logic       keep;
    logic       push;

    always_comb
    begin
        cls.op      = func;
        cls.pivoted = (pivot_x != 32'sd0) || (pivot_y != 32'sd0);
        cls.angle   = angle_deg;
        cls.px      = pivot_x;
        cls.py      = pivot_y;
        cls.idx     = element_index;
        cls.a       = '0;
        cls.b       = '0;
        case (func)
            FN_SCALE:
            begin
                cls.a = scale_x;
                cls.b = scale_y;
            end
            FN_TRANS:
            begin
                cls.a = shift_x;
                cls.b = shift_y;
            end
            FN_LOAD:
            begin
                cls.a = element_value;
            end
            default:
            begin
                cls.a = '0;
                cls.b = '0;
            end
        endcase
        // unused code and zero-angle rotate leave the state alone: drop them
        keep = (func != FN_NONE) && !((func == FN_ROT) && (angle_deg == 32'sd0));
    end

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall && keep;
    assign q_valid  = (count_reg != 2'd0);
    assign q_cmd    = q_mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop && q_valid)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !(q_pop && q_valid))
                count_reg <= count_reg + 2'd1;
            else if (!push && q_pop && q_valid)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= cls;
    end

endmodule

// ===== hdl/tma_cordic.sv =====
// Iterative sine/cosine unit: angle reduction then one CORDIC step per cycle.
// Depends on tma_pkg.
module tma_cordic #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  tma_pkg::fx_t angle,
    output logic         done,
    output tma_pkg::fx_t cos_val,
    output tma_pkg::fx_t sin_val
);
    import tma_pkg::*;

    localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
    localparam logic signed [63:0] FULL    = 64'sd360 <<< 24;
    localparam logic signed [63:0] HALF    = 64'sd180 <<< 24;
    localparam logic signed [63:0] QUARTER = 64'sd90 <<< 24;
    localparam logic signed [63:0] OFFSET  = FULL <<< 15;
    localparam logic signed [63:0] RND     = 64'sd1 <<< (29 - FRAC_BITS);

    localparam logic [1:0] CS_IDLE = 2'd0;
    localparam logic [1:0] CS_MOD  = 2'd1;
    localparam logic [1:0] CS_ITER = 2'd2;
    localparam logic [1:0] CS_OUT  = 2'd3;

    logic [1:0]         state_reg;
    logic [49:0]        u_reg;
    logic [3:0]         sh_reg;
    logic [4:0]         step_reg;
    logic signed [33:0] x_reg, y_reg, z_reg;
    logic               neg_reg;
    logic               done_reg;
    fx_t                cos_reg, sin_reg;

    logic signed [63:0] zp;
    logic [49:0]        lim;
    logic [49:0]        u_next;
    logic signed [63:0] zf;
    logic               fneg;
    logic signed [33:0] dx, dy, at;
    logic signed [33:0] xn, yn;
    logic signed [63:0] xr, yr;

    always_comb
    begin
        zp     = {{32{angle[31]}}, angle} <<< (24 - FRAC_BITS);
        lim    = 50'(FULL) << sh_reg;
        u_next = (u_reg >= lim) ? (u_reg - lim) : u_reg;
        // fold into [-90, 90] degrees, remembering a sign flip
        zf   = {14'd0, u_next};
        fneg = 1'b0;
        if (zf >= HALF)
            zf = zf - FULL;
        if (zf > QUARTER)
        begin
            zf   = zf - HALF;
            fneg = 1'b1;
        end
        else if (zf < -QUARTER)
        begin
            zf   = zf + HALF;
            fneg = 1'b1;
        end
        dx = y_reg >>> step_reg;
        dy = x_reg >>> step_reg;
        at = {2'b00, atan_q24(step_reg)};
        xn = neg_reg ? -x_reg : x_reg;
        yn = neg_reg ? -y_reg : y_reg;
        xr = ($signed({{30{xn[33]}}, xn}) + RND) >>> (30 - FRAC_BITS);
        yr = ($signed({{30{yn[33]}}, yn}) + RND) >>> (30 - FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                CS_IDLE:
                begin
                    if (start)
                        state_reg <= CS_MOD;
                end
                CS_MOD:
                begin
                    if (sh_reg == 4'd0)
                        state_reg <= CS_ITER;
                end
                CS_ITER:
                begin
                    if (step_reg == 5'(NSTEP - 1))
                        state_reg <= CS_OUT;
                end
                CS_OUT:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= CS_IDLE;
                end
                default:
                begin
                    state_reg <= CS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            CS_IDLE:
            begin
                // offset by a multiple of a full turn keeps the value positive
                u_reg  <= 50'(zp + OFFSET);
                sh_reg <= 4'd15;
            end
            CS_MOD:
            begin
                u_reg    <= u_next;
                sh_reg   <= sh_reg - 4'd1;
                z_reg    <= zf[33:0];
                neg_reg  <= fneg;
                x_reg    <= CORDIC_KINV;
                y_reg    <= '0;
                step_reg <= 5'd0;
            end
            CS_ITER:
            begin
                if (z_reg >= 34'sd0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - at;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + at;
                end
                step_reg <= step_reg + 5'd1;
            end
            CS_OUT:
            begin
                cos_reg <= sat32(xr);
                sin_reg <= sat32(yr);
            end
            default:
            begin
                u_reg <= u_reg;
            end
        endcase
    end

    assign done    = done_reg;
    assign cos_val = cos_reg;
    assign sin_val = sin_reg;

endmodule

// ===== hdl/tma_back.sv =====
// Back end: executes queued commands on the banked matrix memory and drives readout.
// Depends on tma_pkg and tma_cordic.
module tma_back #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  tma_pkg::cmd_t q_cmd,
    input  logic          q_valid,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [3:0]    out_index,
    output tma_pkg::fx_t  out_value,
    output logic          out_last
);
    import tma_pkg::*;

    localparam fx_t ONE = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

    localparam logic [2:0] BS_IDLE     = 3'd0;
    localparam logic [2:0] BS_CORDIC   = 3'd1;
    localparam logic [2:0] BS_MUL      = 3'd2;
    localparam logic [2:0] BS_RD_ISSUE = 3'd3;
    localparam logic [2:0] BS_RD_WAIT  = 3'd4;
    localparam logic [2:0] BS_RD_HOLD  = 3'd5;

    logic [2:0]  state_reg;
    cmd_t        cmd_reg;
    logic [1:0]  pass_reg;
    logic        bank_reg;
    logic [31:0] mvalid_reg;
    logic [15:0] ovalid_reg;
    logic [5:0]  t_reg;
    logic        issue_reg;
    logic [3:0]  rd_idx_reg;

    logic [31:0] mmem [0:31];
    logic [31:0] omem [0:15];

    // pipeline: stage 1 read data, stage 2 product, stage 3 accumulate
    logic        s1_v_reg, s2_v_reg;
    logic [3:0]  s1_e_reg, s2_e_reg;
    logic [1:0]  s1_k_reg, s2_k_reg;
    logic        s1_store_reg;
    fx_t         s1_rhs_reg;
    logic [31:0] m_rd_reg, o_rd_reg;
    logic        m_rvld_reg, m_diag_reg, o_rvld_reg;
    logic signed [63:0] prod_reg, acc_reg;

    logic        cs_start, cs_done;
    fx_t         cs_cos, cs_sin;

    logic [1:0]  kind;
    fx_t         op_a, op_b;
    logic [1:0]  last_pass;
    logic        issue_fire;
    logic [4:0]  m_raddr;
    logic [3:0]  o_raddr;
    fx_t         rhs_issue;
    fx_t         m_val, rhs_val;
    logic signed [63:0] term, acc_sum;
    logic        wr_en, pass_done;
    logic [4:0]  wr_addr;

    tma_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cs_start),
        .angle   (q_cmd.angle),
        .done    (cs_done),
        .cos_val (cs_cos),
        .sin_val (cs_sin)
    );

    assign q_pop    = (state_reg == BS_IDLE) && q_valid;
    assign cs_start = q_pop && (q_cmd.op == FN_ROT);

    // operand of the current product; pivoted ops run T(-p), Op, T(p)
    always_comb
    begin
        kind = OK_TRANS;
        op_a = cmd_reg.a;
        op_b = cmd_reg.b;
        case (cmd_reg.op)
            FN_ROT:
            begin
                kind = OK_ROT;
                op_a = cs_cos;
                op_b = cs_sin;
            end
            FN_SCALE:
            begin
                kind = OK_SCALE;
            end
            FN_MULS:
            begin
                kind = OK_STORE;
            end
            default:
            begin
                kind = OK_TRANS;
            end
        endcase
        if (((cmd_reg.op == FN_ROT) || (cmd_reg.op == FN_SCALE)) && cmd_reg.pivoted)
        begin
            last_pass = 2'd2;
            if (pass_reg == 2'd0)
            begin
                kind = OK_TRANS;
                op_a = neg_sat(cmd_reg.px);
                op_b = neg_sat(cmd_reg.py);
            end
            else if (pass_reg == 2'd2)
            begin
                kind = OK_TRANS;
                op_a = cmd_reg.px;
                op_b = cmd_reg.py;
            end
        end
        else
            last_pass = 2'd0;
    end

    assign issue_fire = (state_reg == BS_MUL) && issue_reg;
    // term t: element e = t[5:2] (column i, row j), inner index k = t[1:0]
    assign o_raddr = {t_reg[5:4], t_reg[1:0]};
    assign m_raddr = (state_reg == BS_RD_ISSUE) ? {bank_reg, rd_idx_reg}
                                                : {bank_reg, t_reg[1:0], t_reg[3:2]};

    always_comb
    begin
        case (o_raddr)
            4'd0, 4'd5, 4'd10, 4'd15: rhs_issue = ONE;
            default:                  rhs_issue = '0;
        endcase
        case (kind)
            OK_TRANS:
            begin
                if (o_raddr == 4'd12)
                    rhs_issue = op_a;
                else if (o_raddr == 4'd13)
                    rhs_issue = op_b;
            end
            OK_ROT:
            begin
                if ((o_raddr == 4'd0) || (o_raddr == 4'd5))
                    rhs_issue = op_a;
                else if (o_raddr == 4'd4)
                    rhs_issue = neg_sat(op_b);
                else if (o_raddr == 4'd1)
                    rhs_issue = op_b;
            end
            OK_SCALE:
            begin
                if (o_raddr == 4'd0)
                    rhs_issue = op_a;
                else if (o_raddr == 4'd5)
                    rhs_issue = op_b;
            end
            default:
            begin
                rhs_issue = '0;
            end
        endcase
    end

    // never-written matrix entries read as identity, operand entries as zero
    assign m_val   = m_rvld_reg ? m_rd_reg : (m_diag_reg ? ONE : 32'sd0);
    assign rhs_val = s1_store_reg ? (o_rvld_reg ? o_rd_reg : 32'sd0) : s1_rhs_reg;

    assign term      = (prod_reg + RND) >>> FRAC_BITS;
    assign acc_sum   = ((s2_k_reg == 2'd0) ? 64'sd0 : acc_reg) + term;
    assign wr_en     = s2_v_reg && (s2_k_reg == 2'd3);
    assign wr_addr   = {~bank_reg, s2_e_reg};
    assign pass_done = wr_en && (s2_e_reg == 4'd15);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BS_IDLE;
            pass_reg   <= 2'd0;
            bank_reg   <= 1'b0;
            mvalid_reg <= '0;
            ovalid_reg <= '0;
            t_reg      <= 6'd0;
            issue_reg  <= 1'b0;
            rd_idx_reg <= 4'd0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            out_valid  <= 1'b0;
        end
        else
        begin
            s1_v_reg <= issue_fire;
            s2_v_reg <= s1_v_reg;
            if (wr_en)
                mvalid_reg[wr_addr] <= 1'b1;
            case (state_reg)
                BS_IDLE:
                begin
                    pass_reg <= 2'd0;
                    t_reg    <= 6'd0;
                    if (q_valid)
                    begin
                        case (q_cmd.op)
                            FN_IDENT:
                            begin
                                if (bank_reg)
                                    mvalid_reg[31:16] <= '0;
                                else
                                    mvalid_reg[15:0] <= '0;
                            end
                            FN_LOAD:
                            begin
                                ovalid_reg[q_cmd.idx] <= 1'b1;
                            end
                            FN_ROT:
                            begin
                                state_reg <= BS_CORDIC;
                            end
                            FN_SCALE, FN_TRANS, FN_MULS:
                            begin
                                state_reg <= BS_MUL;
                                issue_reg <= 1'b1;
                            end
                            FN_READ:
                            begin
                                rd_idx_reg <= 4'd0;
                                state_reg  <= BS_RD_ISSUE;
                            end
                            default:
                            begin
                                state_reg <= BS_IDLE;
                            end
                        endcase
                    end
                end
                BS_CORDIC:
                begin
                    if (cs_done)
                    begin
                        state_reg <= BS_MUL;
                        issue_reg <= 1'b1;
                    end
                end
                BS_MUL:
                begin
                    if (issue_reg)
                    begin
                        t_reg <= t_reg + 6'd1;
                        if (t_reg == 6'd63)
                            issue_reg <= 1'b0;
                    end
                    if (pass_done)
                    begin
                        bank_reg <= ~bank_reg;
                        if (pass_reg == last_pass)
                            state_reg <= BS_IDLE;
                        else
                        begin
                            pass_reg  <= pass_reg + 2'd1;
                            t_reg     <= 6'd0;
                            issue_reg <= 1'b1;
                        end
                    end
                end
                BS_RD_ISSUE:
                begin
                    state_reg <= BS_RD_WAIT;
                end
                BS_RD_WAIT:
                begin
                    out_valid <= 1'b1;
                    state_reg <= BS_RD_HOLD;
                end
                BS_RD_HOLD:
                begin
                    if (!out_stall)
                    begin
                        out_valid <= 1'b0;
                        if (rd_idx_reg == 4'd15)
                            state_reg <= BS_IDLE;
                        else
                        begin
                            rd_idx_reg <= rd_idx_reg + 4'd1;
                            state_reg  <= BS_RD_ISSUE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= BS_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cmd_reg <= q_cmd;
        if (q_pop && (q_cmd.op == FN_LOAD))
            omem[q_cmd.idx] <= q_cmd.a;
        if (wr_en)
            mmem[wr_addr] <= sat32(acc_sum);
        m_rd_reg     <= mmem[m_raddr];
        m_rvld_reg   <= mvalid_reg[m_raddr];
        m_diag_reg   <= (m_raddr[3:2] == m_raddr[1:0]);
        o_rd_reg     <= omem[o_raddr];
        o_rvld_reg   <= ovalid_reg[o_raddr];
        s1_rhs_reg   <= rhs_issue;
        s1_store_reg <= (kind == OK_STORE);
        s1_e_reg     <= t_reg[5:2];
        s1_k_reg     <= t_reg[1:0];
        prod_reg     <= 64'(m_val) * 64'(rhs_val);
        s2_e_reg     <= s1_e_reg;
        s2_k_reg     <= s1_k_reg;
        if (s2_v_reg)
            acc_reg <= acc_sum;
        if (state_reg == BS_RD_WAIT)
        begin
            out_index <= rd_idx_reg;
            out_value <= m_val;
            out_last  <= (rd_idx_reg == 4'd15);
        end
    end

endmodule

// ===== hdl/transform_matrix_accumulator.sv =====
// 4x4 column-major Q16.16 transform matrix accumulator. Each transaction carries one
// operation (identity, rotate about Z, scale, translate, load operand element,
// multiply by operand, read out); updates right-multiply the held matrix with
// rounding and saturation. Identity and load are done in the back end's idle state,
// and the unused code and a zero-angle rotate never enter the queue; each 4x4 product
// runs its 64 terms through the single 32x32 multiplier pipeline after dispatch from
// the idle state; a rotate first runs angle reduction and CORDIC iteration; a pivoted
// scale or rotate runs three products; a readout steps each element through issue,
// wait and hold states and holds it while the output is stalled. A two-entry command
// queue lets input transactions be taken while the back end is busy.
// Depends on tma_pkg, tma_front and tma_back.
module transform_matrix_accumulator #(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic [2:0]   func,
    input  tma_pkg::fx_t angle_deg,
    input  tma_pkg::fx_t pivot_x,
    input  tma_pkg::fx_t pivot_y,
    input  tma_pkg::fx_t scale_x,
    input  tma_pkg::fx_t scale_y,
    input  tma_pkg::fx_t shift_x,
    input  tma_pkg::fx_t shift_y,
    input  logic [3:0]   element_index,
    input  tma_pkg::fx_t element_value,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [3:0]   out_index,
    output tma_pkg::fx_t out_value,
    output logic         out_last
);
    import tma_pkg::*;

    cmd_t q_cmd;
    logic q_valid;
    logic q_pop;

    // front end: classify and queue
    tma_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .angle_deg     (angle_deg),
        .pivot_x       (pivot_x),
        .pivot_y       (pivot_y),
        .scale_x       (scale_x),
        .scale_y       (scale_y),
        .shift_x       (shift_x),
        .shift_y       (shift_y),
        .element_index (element_index),
        .element_value (element_value),
        .q_cmd         (q_cmd),
        .q_valid       (q_valid),
        .q_pop         (q_pop)
    );

    // back end: CORDIC, matrix products, readout
    tma_back #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_cmd     (q_cmd),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_index (out_index),
        .out_value (out_value),
        .out_last  (out_last)
    );

endmodule

// ===== hdl/tma_checker.sv =====
// Port-level checks on the readout channel of the transform matrix block.
// Depends on assert_macros.svh; bound to transform_matrix_accumulator.
`include "assert_macros.svh"
module tma_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  out_index,
    input logic [31:0] out_value,
    input logic        out_last
);
    // last flag marks exactly the final element
    `TMA_ASSERT_IMP(a_last_idx, clk, rst_n, out_valid, (out_last == (out_index == 4'd15)))
    // stalled transaction holds
    `TMA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_index) && $stable(out_value) && $stable(out_last))
    // each element is fetched anew after its transaction
    `TMA_ASSERT_NXT(a_gap, clk, rst_n, out_valid && !out_stall, !out_valid)
endmodule

bind transform_matrix_accumulator tma_checker u_tma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_index (out_index),
    .out_value (out_value),
    .out_last  (out_last)
);
